[rtl/gbr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian blur RGB package
// Shared constants, register indexes and transfer types of the blur block.
// ----------------------------------------------------------------------------
package gbr_pkg;

    localparam int KERNEL_HALF_DEF = 3;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int HEIGHT_CAP      = 4096;

    localparam int ROW_W      = 13;
    localparam int IW_W       = 11;
    localparam int IH_W       = 13;
    localparam int WGT_W      = 16;
    localparam int WROW_W     = 48;
    localparam int QUAD_MAX   = 3;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CHAN_W     = 8;
    localparam int NCH        = 3;
    localparam int PIX_W      = NCH * CHAN_W;
    localparam int FIFO_DEPTH = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_WEIGHTS_ROW0 = 3'd2,
        CFG_WEIGHTS_ROW1 = 3'd3,
        CFG_WEIGHTS_ROW2 = 3'd4
    } cfg_index_t;

    typedef logic [WROW_W-1:0] wrow_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic              is_filler;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic              frame_last;
    } result_t;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } stage_t;

endpackage
`default_nettype wire

[rtl/gbr_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Line store and window
// Column history memory with read-modify-write and the square pixel window.
// ----------------------------------------------------------------------------
module gbr_window #(
    parameter int KERNEL_HALF = gbr_pkg::KERNEL_HALF_DEF,
    parameter int MAX_WIDTH   = gbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gbr_pkg::stage_t                 s0_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]    s0_col,
    input  gbr_pkg::pix_t                   s0_pix,
    input  logic [gbr_pkg::ROW_W-1:0]       s0_orow,
    input  logic [$clog2(MAX_WIDTH)-1:0]    s0_ocol,
    output gbr_pkg::stage_t                 s2_ctrl,
    output logic [gbr_pkg::ROW_W-1:0]       s2_orow,
    output logic [$clog2(MAX_WIDTH)-1:0]    s2_ocol,
    output gbr_pkg::pix_t                   win [2*KERNEL_HALF-1][2*KERNEL_HALF-1]
);
    import gbr_pkg::*;

    localparam int RAD   = KERNEL_HALF - 1;
    localparam int NT    = 2 * RAD + 1;
    localparam int SLOTS = (2 * RAD > 0) ? 2 * RAD : 1;
    localparam int ENT_W = SLOTS * PIX_W;
    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [ENT_W-1:0] mem [MAX_WIDTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic [ENT_W-1:0] fwd_data_reg;
    logic             fwd_hit_reg;
    logic [ENT_W-1:0] rd_entry;
    logic [ENT_W-1:0] wr_data;

    stage_t           s1_ctrl_reg;
    logic [COL_W-1:0] s1_col_reg;
    pix_t             s1_pix_reg;
    logic [ROW_W-1:0] s1_orow_reg;
    logic [COL_W-1:0] s1_ocol_reg;
    stage_t           s2_ctrl_reg;
    logic [ROW_W-1:0] s2_orow_reg;
    logic [COL_W-1:0] s2_ocol_reg;

    pix_t col_vec [NT];
    pix_t win_reg [NT][NT];

    always_ff @(posedge clk)
    begin
        if (s1_ctrl_reg.valid)
        begin
            mem[s1_col_reg] <= wr_data;
        end
        rd_data_reg <= mem[s0_col];
    end

    // A read that meets a write to its column in the same cycle takes the new entry.
    always_comb
    begin
        rd_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        for (int j = 0; j < NT - 1; j++)
        begin
            col_vec[j] = rd_entry[j*PIX_W +: PIX_W];
        end
        col_vec[NT-1] = s1_pix_reg;
        wr_data = '0;
        for (int j = 0; j < NT - 1; j++)
        begin
            wr_data[j*PIX_W +: PIX_W] = col_vec[j+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            s1_ctrl_reg       <= s0_ctrl;
            s2_ctrl_reg.valid <= s1_ctrl_reg.valid && s1_ctrl_reg.emit;
            s2_ctrl_reg.emit  <= s1_ctrl_reg.valid && s1_ctrl_reg.emit;
            s2_ctrl_reg.last  <= s1_ctrl_reg.last;
            fwd_hit_reg       <= s1_ctrl_reg.valid && s0_ctrl.valid
                                 && (s1_col_reg == s0_col);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_col_reg   <= s0_col;
        s1_pix_reg   <= s0_pix;
        s1_orow_reg  <= s0_orow;
        s1_ocol_reg  <= s0_ocol;
        fwd_data_reg <= wr_data;
        s2_orow_reg  <= s1_orow_reg;
        s2_ocol_reg  <= s1_ocol_reg;
        if (s1_ctrl_reg.valid)
        begin
            for (int i = 0; i < NT - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[NT-1] <= col_vec;
        end
    end

    assign s2_ctrl = s2_ctrl_reg;
    assign s2_orow = s2_orow_reg;
    assign s2_ocol = s2_ocol_reg;
    assign win     = win_reg;

endmodule
`default_nettype wire

[rtl/gbr_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Blur multiply-accumulate
// Edge masking, symmetric pre-add, weight products and saturating sum.
// ----------------------------------------------------------------------------
module gbr_mac #(
    parameter int KERNEL_HALF = gbr_pkg::KERNEL_HALF_DEF,
    parameter int MAX_WIDTH   = gbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gbr_pkg::stage_t                   s2_ctrl,
    input  logic [gbr_pkg::ROW_W-1:0]         s2_orow,
    input  logic [$clog2(MAX_WIDTH)-1:0]      s2_ocol,
    input  gbr_pkg::pix_t                     win [2*KERNEL_HALF-1][2*KERNEL_HALF-1],
    input  logic [$clog2(MAX_WIDTH+1)-1:0]    img_w,
    input  logic [gbr_pkg::ROW_W-1:0]         img_h,
    input  gbr_pkg::wrow_t                    weights [gbr_pkg::QUAD_MAX],
    output logic                              res_valid,
    output gbr_pkg::result_t                  res
);
    import gbr_pkg::*;

    localparam int RAD    = KERNEL_HALF - 1;
    localparam int NT     = 2 * RAD + 1;
    localparam int NQ     = RAD + 1;
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int CW     = WID_W + 1;
    localparam int RW     = ROW_W + 1;
    localparam int GRP_W  = CHAN_W + 2;
    localparam int PROD_W = GRP_W + WGT_W;
    localparam int ACC_W  = PROD_W + $clog2(NQ * NQ + 1);
    localparam int HI_W   = ACC_W - WGT_W;

    logic [NT-1:0]     col_ok;
    logic [NT-1:0]     row_ok;
    logic [GRP_W-1:0]  grp [NCH][NQ][NQ];
    logic [GRP_W-1:0]  grp_reg [NCH][NQ][NQ];
    logic [PROD_W-1:0] prod [NCH][NQ][NQ];
    logic [PROD_W-1:0] prod_reg [NCH][NQ][NQ];
    logic [ACC_W-1:0]  acc [NCH];
    stage_t            s3_ctrl_reg;
    stage_t            s4_ctrl_reg;

    function automatic logic [CHAN_W-1:0] sat8(input logic [ACC_W-1:0] sum);
        logic [HI_W-1:0] hi;
        begin
            hi = sum[ACC_W-1:WGT_W];
            return (hi > HI_W'(255)) ? 8'hFF : hi[CHAN_W-1:0];
        end
    endfunction

    // Taps outside the image are dropped; taps of equal weight are added first.
    always_comb
    begin
        logic [CW-1:0] cpos;
        logic [RW-1:0] rpos;
        int dya;
        int dxb;
        for (int i = 0; i < NT; i++)
        begin
            cpos      = CW'(s2_ocol) + CW'(i);
            col_ok[i] = (cpos >= CW'(RAD)) && (cpos < CW'(img_w) + CW'(RAD));
            rpos      = RW'(s2_orow) + RW'(i);
            row_ok[i] = (rpos >= RW'(RAD)) && (rpos < RW'(img_h) + RW'(RAD));
        end
        for (int c = 0; c < NCH; c++)
        begin
            for (int a = 0; a < NQ; a++)
            begin
                for (int b = 0; b < NQ; b++)
                begin
                    grp[c][a][b] = '0;
                end
            end
        end
        for (int i = 0; i < NT; i++)
        begin
            for (int j = 0; j < NT; j++)
            begin
                dxb = (i > RAD) ? i - RAD : RAD - i;
                dya = (j > RAD) ? j - RAD : RAD - j;
                if (col_ok[i] && row_ok[j])
                begin
                    grp[0][dya][dxb] = grp[0][dya][dxb] + GRP_W'(win[i][j].red);
                    grp[1][dya][dxb] = grp[1][dya][dxb] + GRP_W'(win[i][j].green);
                    grp[2][dya][dxb] = grp[2][dya][dxb] + GRP_W'(win[i][j].blue);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            for (int a = 0; a < NQ; a++)
            begin
                for (int b = 0; b < NQ; b++)
                begin
                    prod[c][a][b] = PROD_W'(grp_reg[c][a][b])
                                    * PROD_W'(weights[a][b*WGT_W +: WGT_W]);
                end
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            acc[c] = '0;
            for (int a = 0; a < NQ; a++)
            begin
                for (int b = 0; b < NQ; b++)
                begin
                    acc[c] = acc[c] + ACC_W'(prod_reg[c][a][b]);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_ctrl_reg <= '0;
            s4_ctrl_reg <= '0;
        end
        else
        begin
            s3_ctrl_reg <= s2_ctrl;
            s4_ctrl_reg <= s3_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg  <= grp;
        prod_reg <= prod;
    end

    assign res_valid      = s4_ctrl_reg.valid;
    assign res.out_red    = sat8(acc[0]);
    assign res.out_green  = sat8(acc[1]);
    assign res.out_blue   = sat8(acc[2]);
    assign res.frame_last = s4_ctrl_reg.last;

endmodule
`default_nettype wire

[rtl/gaussian_blur_rgb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Gaussian blur RGB top level
// Square Gaussian blur of a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the item channel in raster order, one transfer per clock
// unless stalled. Each transfer is accepted when item_valid is high and
// item_stall is low. Results leave on the result channel under the same
// valid/stall rule. Results are registered; the transfer that completes a
// window trails its center pixel by (KERNEL_HALF-1) rows plus (KERNEL_HALF-1)
// pixels. Once primed the block delivers one result per accepted pixel.
// After the last pixel of a frame, filler transfers flush the remaining
// results; the result with frame_last set ends the frame and the next
// transfer starts a new one. The line store has one read and one write port
// and is written for each column moved, which allows one pixel per clock.
// For frames of no more pixels than the window lag, input is held after the
// last pixel while the window is primed. An eight-entry output queue takes
// results while the receiver stalls; item_stall rises during priming or once
// queued plus in-flight results fill it. Reset clears the counters and sets
// width 640, height 480, weights zero. The user writes configuration between
// frames through cfg_we/cfg_index/cfg_data; the block does not enforce it.
// ----------------------------------------------------------------------------
module gaussian_blur_rgb_top #(
    parameter int KERNEL_HALF = gbr_pkg::KERNEL_HALF_DEF,
    parameter int MAX_WIDTH   = gbr_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  gbr_pkg::item_t                   item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output gbr_pkg::result_t                 result,
    input  logic                             cfg_we,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gbr_pkg::*;

    localparam int RAD        = KERNEL_HALF - 1;
    localparam int NT         = 2 * RAD + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = $clog2(MAX_WIDTH + 1);
    localparam int VIDX_W     = $clog2((HEIGHT_CAP + 2 * KERNEL_HALF) * MAX_WIDTH);
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int OCC_W      = CNT_W + 1;
    localparam int PIPE_DEPTH = 4;
    localparam int INF_W      = $clog2(PIPE_DEPTH + 1);

    logic [IW_W-1:0]   image_width_reg;
    logic [IH_W-1:0]   image_height_reg;
    wrow_t             weights_reg [QUAD_MAX];

    logic [COL_W-1:0]  vcol_reg, vcol_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [VIDX_W-1:0] vidx_reg, vidx_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic [VIDX_W-1:0] pad_reg, pad_next;
    logic [INF_W-1:0]  inflight_reg, inflight_next;

    result_t           fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  fifo_cnt_reg;

    logic [WID_W-1:0]  img_w;
    logic [ROW_W-1:0]  img_h;
    logic [VIDX_W-1:0] lag;
    logic [VIDX_W-1:0] vidx_inc;
    logic [OCC_W-1:0]  occ;
    logic              accept;
    logic              all_in;
    logic              pix_go;
    logic              flush_go;
    logic              pad_go;
    logic              v_go;
    logic              col_wrap;
    logic              out_wrap;
    logic              frame_end;
    stage_t            s0_ctrl;
    pix_t              s0_pix;

    stage_t            s2_ctrl;
    logic [ROW_W-1:0]  s2_orow;
    logic [COL_W-1:0]  s2_ocol;
    pix_t              win [NT][NT];
    logic              mac_valid;
    result_t           mac_res;
    logic              push;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IW_W'(640);
            image_height_reg <= IH_W'(480);
            for (int i = 0; i < QUAD_MAX; i++)
            begin
                weights_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IW_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IH_W-1:0];
                CFG_WEIGHTS_ROW0: weights_reg[0]   <= cfg_data[WROW_W-1:0];
                CFG_WEIGHTS_ROW1: weights_reg[1]   <= cfg_data[WROW_W-1:0];
                CFG_WEIGHTS_ROW2: weights_reg[2]   <= cfg_data[WROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg == '0)
            img_w = WID_W'(1);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            img_w = WID_W'(MAX_WIDTH);
        else
            img_w = WID_W'(image_width_reg);
        if (image_height_reg == '0)
            img_h = ROW_W'(1);
        else if (32'(image_height_reg) > 32'(HEIGHT_CAP))
            img_h = ROW_W'(HEIGHT_CAP);
        else
            img_h = ROW_W'(image_height_reg);
        lag = VIDX_W'(RAD) * VIDX_W'(img_w) + VIDX_W'(RAD);
    end

    // Every pixel, flush transfer and priming step moves one column through
    // the window; a result is due once the window has run a full lag ahead.
    always_comb
    begin
        occ        = OCC_W'(fifo_cnt_reg) + OCC_W'(inflight_reg);
        item_stall = (pad_reg != '0) || (occ >= OCC_W'(FIFO_DEPTH));
        accept     = item_valid && !item_stall;
        all_in     = in_row_reg >= img_h;
        pix_go     = accept && !all_in && !item.is_filler;
        flush_go   = accept && all_in;
        pad_go     = (pad_reg != '0) && (occ < OCC_W'(FIFO_DEPTH));
        v_go       = pix_go || flush_go || pad_go;
        col_wrap   = (WID_W'(vcol_reg) + WID_W'(1)) >= img_w;
        out_wrap   = (WID_W'(ocol_reg) + WID_W'(1)) >= img_w;
        vidx_inc   = vidx_reg + VIDX_W'(1);

        s0_ctrl.valid = v_go;
        s0_ctrl.emit  = v_go && (vidx_reg >= lag);
        s0_ctrl.last  = s0_ctrl.emit && out_wrap && ((orow_reg + ROW_W'(1)) >= img_h);
        frame_end     = s0_ctrl.last;
        if (pix_go)
            s0_pix = '{red: item.in_red, green: item.in_green, blue: item.in_blue};
        else
            s0_pix = '0;

        vcol_next     = vcol_reg;
        in_row_next   = in_row_reg;
        vidx_next     = vidx_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        pad_next      = pad_reg;
        inflight_next = inflight_reg + INF_W'(s0_ctrl.emit) - INF_W'(mac_valid);

        if (v_go)
        begin
            vcol_next = col_wrap ? '0 : vcol_reg + COL_W'(1);
            vidx_next = vidx_inc;
        end
        if (pix_go && col_wrap)
        begin
            in_row_next = in_row_reg + ROW_W'(1);
            if ((in_row_reg + ROW_W'(1)) >= img_h)
            begin
                pad_next = (lag >= vidx_inc) ? lag - vidx_inc + VIDX_W'(1) : '0;
            end
        end
        if (pad_go)
        begin
            pad_next = pad_reg - VIDX_W'(1);
        end
        if (s0_ctrl.emit)
        begin
            if (out_wrap)
            begin
                ocol_next = '0;
                orow_next = orow_reg + ROW_W'(1);
            end
            else
            begin
                ocol_next = ocol_reg + COL_W'(1);
            end
        end
        if (frame_end)
        begin
            vcol_next   = '0;
            in_row_next = '0;
            vidx_next   = '0;
            orow_next   = '0;
            ocol_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcol_reg     <= '0;
            in_row_reg   <= '0;
            vidx_reg     <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            pad_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            vcol_reg     <= vcol_next;
            in_row_reg   <= in_row_next;
            vidx_reg     <= vidx_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            pad_reg      <= pad_next;
            inflight_reg <= inflight_next;
        end
    end

    gbr_window #(
        .KERNEL_HALF (KERNEL_HALF),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .s0_ctrl (s0_ctrl),
        .s0_col  (vcol_reg),
        .s0_pix  (s0_pix),
        .s0_orow (orow_reg),
        .s0_ocol (ocol_reg),
        .s2_ctrl (s2_ctrl),
        .s2_orow (s2_orow),
        .s2_ocol (s2_ocol),
        .win     (win)
    );

    gbr_mac #(
        .KERNEL_HALF (KERNEL_HALF),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_ctrl   (s2_ctrl),
        .s2_orow   (s2_orow),
        .s2_ocol   (s2_ocol),
        .win       (win),
        .img_w     (img_w),
        .img_h     (img_h),
        .weights   (weights_reg),
        .res_valid (mac_valid),
        .res       (mac_res)
    );

    assign push         = mac_valid;
    assign result_valid = fifo_cnt_reg != '0;
    assign pop          = result_valid && !result_stall;
    assign result       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= mac_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_reg + PTR_W'(push);
            rd_ptr_reg   <= rd_ptr_reg + PTR_W'(pop);
            fifo_cnt_reg <= fifo_cnt_reg + CNT_W'(push) - CNT_W'(pop);
        end
    end

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fifo_cnt_reg < CNT_W'(FIFO_DEPTH)) || pop)
        else $error("Result queue written while full.");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (vidx_reg == '0) && (in_row_reg == '0) && (pad_reg == '0))
        else $error("Frame counters not cleared after the last result.");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INF_W'(PIPE_DEPTH))
        else $error("More results in flight than pipeline stages.");

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian blur RGB testbench
// Streams raster frames of random geometry and weights through the blur block
// and checks each output pixel against a built-in model of the filter.
// One frame at known settings carries typed-in results. Both handshakes idle
// at random in several phases, and the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module tb;
    import gbr_pkg::*;

    localparam int RING  = 6;
    localparam int MAXW  = 1024;
    localparam int RAD   = 2;
    localparam int NRAND = 1750;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    item_t            item;
    logic             result_valid;
    logic             result_stall;
    result_t          result;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gaussian_blur_rgb_top u_top (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Model state of the blur.
    logic [PIX_W-1:0]  blur_ring [RING*MAXW];
    int unsigned       blur_col, blur_row, blur_outs;
    logic [IW_W-1:0]   reg_width;
    logic [IH_W-1:0]   reg_height;
    wrow_t             reg_quad [3];

    result_t pixels_due [$];
    int      errors;
    int      phase;
    int      counted;
    bit      hold_done;
    int      hold_left;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    row_t plan [$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = reg_width;
        if (w < 1) w = 1;
        if (w > MAXW) w = MAXW;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = reg_height;
        if (h < 1) h = 1;
        if (h > HEIGHT_CAP) h = HEIGHT_CAP;
        return h;
    endfunction

    function automatic void set_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_width = val[IW_W-1:0];
            CFG_IMAGE_HEIGHT: reg_height = val[IH_W-1:0];
            CFG_WEIGHTS_ROW0: reg_quad[0] = val;
            CFG_WEIGHTS_ROW1: reg_quad[1] = val;
            CFG_WEIGHTS_ROW2: reg_quad[2] = val;
            default: ;
        endcase
    endfunction

    function automatic bit blur_pixel(item_t it, output result_t r);
        int unsigned w, h, total, n_in, orow, ocol, dy, dx;
        int          rr, cc;
        logic [PIX_W-1:0] px;
        longint unsigned sr, sg, sb, wt;
        w = eff_width();
        h = eff_height();
        total = w * h;
        sr = 0; sg = 0; sb = 0;
        r = '0;
        if (blur_row >= h && blur_outs >= total)
        begin
            blur_row = 0; blur_col = 0; blur_outs = 0;
        end
        if (blur_row < h)
        begin
            if (it.is_filler)
                return 0;
            blur_ring[(blur_row % RING) * MAXW + (blur_col % MAXW)] =
                {it.in_red, it.in_green, it.in_blue};
            blur_col++;
            if (blur_col >= w)
            begin
                blur_col = 0;
                blur_row++;
            end
        end
        n_in = (blur_row >= h) ? total : blur_row * w + blur_col;
        if (blur_outs >= total)
            return 0;
        if (!(n_in >= total || n_in > blur_outs + RAD * w + RAD))
            return 0;
        orow = blur_outs / w;
        ocol = blur_outs % w;
        for (rr = int'(orow) - RAD; rr <= int'(orow) + RAD; rr++)
        begin
            if (rr < 0 || rr >= int'(h))
                continue;
            for (cc = int'(ocol) - RAD; cc <= int'(ocol) + RAD; cc++)
            begin
                if (cc < 0 || cc >= int'(w))
                    continue;
                px = blur_ring[(rr % RING) * MAXW + cc];
                dy = (rr > int'(orow)) ? rr - orow : orow - rr;
                dx = (cc > int'(ocol)) ? cc - ocol : ocol - cc;
                wt = (reg_quad[dy] >> (WGT_W * dx)) & 16'hFFFF;
                sr += px[23:16] * wt;
                sg += px[15:8] * wt;
                sb += px[7:0] * wt;
            end
        end
        blur_outs++;
        if (blur_outs >= total)
        begin
            r.frame_last = 1'b1;
            blur_row = 0; blur_col = 0; blur_outs = 0;
        end
        r.out_red   = ((sr >> 16) > 255) ? 8'hFF : 8'((sr >> 16));
        r.out_green = ((sg >> 16) > 255) ? 8'hFF : 8'((sg >> 16));
        r.out_blue  = ((sb >> 16) > 255) ? 8'hFF : 8'((sb >> 16));
        return 1;
    endfunction

    function automatic bit sender_idles();
        case (phase)
            1: return $urandom_range(0, 99) < 55;
            3: return $urandom_range(0, 99) < 15;
            default: return 0;
        endcase
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        set_register(idx, val);
    endtask

    task automatic wait_idle();
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Offers one transfer, and books its result once accepted.
    task automatic send_pixel(item_t it, bit typed, result_t given, output bit made);
        result_t r;
        while (sender_idles())
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        made = blur_pixel(it, r);
        if (made)
            pixels_due.push_back(typed ? given : r);
        @(negedge clk);
    endtask

    function automatic item_t rand_pixel(bit filler);
        item_t it;
        it.in_red = $urandom_range(0, 255);
        it.in_green = $urandom_range(0, 255);
        it.in_blue = $urandom_range(0, 255);
        it.is_filler = filler;
        return it;
    endfunction

    function automatic wrow_t rand_quad();
        wrow_t q;
        for (int k = 0; k < 3; k++)
            q[k*WGT_W +: WGT_W] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 4000);
        return q;
    endfunction

    task automatic run_frame(int wv, int hv);
        int unsigned total;
        bit made;
        write_reg(CFG_IMAGE_WIDTH, wv);
        write_reg(CFG_IMAGE_HEIGHT, hv);
        total = eff_width() * eff_height();
        for (int n = 0; n < total; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_pixel(rand_pixel(1'b1), 0, '0, made);
            send_pixel(rand_pixel(1'b0), 0, '0, made);
            counted++;
            phase = (counted / 150) % 4;
        end
        while (blur_row != 0 || blur_outs != 0)
        begin
            send_pixel(rand_pixel($urandom_range(0, 1)), 0, '0, made);
            counted++;
            phase = (counted / 150) % 4;
        end
        item_valid <= 1'b0;
        wait_idle();
    endtask

    task automatic add_row(item_t it, bit typed, result_t r);
        row_t x;
        x.it = it;
        x.typed = typed;
        x.res = r;
        plan.push_back(x);
    endtask

    // Receiver: random stalls by phase, with one long hold-off.
    always @(negedge clk)
    begin
        if (!hold_done && counted >= 500)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (phase == 2)
            result_stall <= $urandom_range(0, 99) < 55;
        else if (phase == 3)
            result_stall <= $urandom_range(0, 99) < 15;
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pixels_due.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result);
                errors++;
            end
            else
            begin
                want = pixels_due.pop_front();
                if (want.out_red !== result.out_red || want.out_green !== result.out_green
                    || want.out_blue !== result.out_blue
                    || want.frame_last !== result.frame_last)
                begin
                    $display("%0t: expected %h, got %h", $time, want, result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        result_t z, zl;
        bit made;
        int wv, hv;
        errors = 0; phase = 0; counted = 0; hold_done = 0; hold_left = 0;
        item_valid = 1'b0; item = '0; result_stall = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_IMAGE_WIDTH; cfg_data = '0;
        blur_col = 0; blur_row = 0; blur_outs = 0;
        reg_width = 640; reg_height = 480;
        for (int k = 0; k < 3; k++)
            reg_quad[k] = '0;
        for (int k = 0; k < RING * MAXW; k++)
            blur_ring[k] = '0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With the reset weights of zero every output is black.
        z = '0;
        zl = '0;
        zl.frame_last = 1'b1;
        write_reg(CFG_IMAGE_WIDTH, 2);
        write_reg(CFG_IMAGE_HEIGHT, 2);
        add_row('{8'hFF, 8'hFF, 8'hFF, 1'b0}, 0, z);
        add_row('{8'h00, 8'h00, 8'h00, 1'b0}, 0, z);
        add_row('{8'h12, 8'h34, 8'h56, 1'b1}, 0, z);
        add_row('{8'hFF, 8'h00, 8'hFF, 1'b0}, 0, z);
        add_row('{8'h00, 8'hFF, 8'h00, 1'b0}, 1, z);
        add_row('{8'h00, 8'h00, 8'h00, 1'b1}, 1, z);
        add_row('{8'hAA, 8'h55, 8'hAA, 1'b0}, 1, z);
        add_row('{8'h00, 8'h00, 8'h00, 1'b1}, 1, zl);
        foreach (plan[i])
            send_pixel(plan[i].it, plan[i].typed, plan[i].res, made);
        item_valid <= 1'b0;
        wait_idle();

        // Full-scale weights saturate; checked by the model.
        plan.delete();
        write_reg(CFG_WEIGHTS_ROW0, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_WEIGHTS_ROW1, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_WEIGHTS_ROW2, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_IMAGE_WIDTH, 3);
        for (int k = 0; k < 6; k++)
            add_row('{8'hFF, 8'h00, 8'h80, 1'b0}, 0, z);
        for (int k = 0; k < 5; k++)
            add_row('{8'h00, 8'h00, 8'h00, 1'b1}, 0, z);
        foreach (plan[i])
            send_pixel(plan[i].it, plan[i].typed, plan[i].res, made);
        item_valid <= 1'b0;
        wait_idle();

        for (int f = 0; counted < NRAND; f++)
        begin
            write_reg(CFG_WEIGHTS_ROW0, rand_quad());
            write_reg(CFG_WEIGHTS_ROW1, rand_quad());
            write_reg(CFG_WEIGHTS_ROW2, rand_quad());
            case (f)
                2: begin wv = 0; hv = 0; end
                5: begin wv = 2047; hv = 1; end
                8: begin wv = 1; hv = 8191; end
                11: begin wv = 1024; hv = 3; end
                default:
                begin
                    wv = $urandom_range(1, 12);
                    hv = $urandom_range(1, 8);
                end
            endcase
            run_frame(wv, hv);
        end

        item_valid <= 1'b0;
        wait_idle();
        if (errors == 0 && pixels_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
